### sv/pgo_pkg.sv
// Shared constants, register codes and elaboration-time helpers for the pixel gain block.
`default_nettype none
package pgo_pkg;

  localparam int PIX_W     = 16;
  localparam int MASK_W    = 4;
  localparam int OFFSET_W  = 25;
  localparam int GAIN_W    = 24;
  localparam int EXP_W     = 24;
  localparam int CFG_W     = 25;
  localparam int CFG_IDX_W = 2;
  localparam int REG_FRAC  = 16;
  localparam int NCHAN     = 4;

  localparam logic [PIX_W-1:0] FULL_SCALE = 16'hFFFF;

  localparam logic [MASK_W-1:0]   MASK_RST   = 4'd7;
  localparam logic [OFFSET_W-1:0] OFFSET_RST = '0;
  localparam logic [GAIN_W-1:0]   GAIN_RST   = 24'd65536;
  localparam logic [EXP_W-1:0]    EXP_RST    = 24'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MASK     = 2'd0,
    REG_OFFSET   = 2'd1,
    REG_GAIN     = 2'd2,
    REG_EXPONENT = 2'd3
  } cfg_reg_t;

  // integer square root, floor
  function automatic longint unsigned isqrt64(input longint unsigned a);
    longint unsigned r;
    longint unsigned bit_v;
    longint unsigned aa;
    r = 0;
    aa = a;
    bit_v = 64'd1 << 62;
    while (bit_v > aa) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (aa >= r + bit_v) begin
        aa = aa - (r + bit_v);
        r = (r >> 1) + bit_v;
      end else begin
        r = r >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return r;
  endfunction

  // 2^-(2^-i) in Q.f, i = 1..f
  function automatic longint unsigned exp_root(input int f, input int i);
    longint unsigned r;
    int j;
    r = isqrt64(64'd1 << (2 * f - 1));
    for (j = 1; j < i; j++) r = isqrt64(r << f);
    return r;
  endfunction

  // log2(65535) in Q.f
  function automatic longint unsigned log2_full(input int f);
    longint unsigned u;
    longint unsigned frac;
    longint unsigned one;
    int j;
    one = 64'd1 << f;
    u = (64'd65535 << f) >> 15;
    frac = 0;
    for (j = 0; j < f; j++) begin
      u = (u * u) >> f;
      frac = frac << 1;
      if (u >= 2 * one) begin
        u = u >> 1;
        frac = frac | 64'd1;
      end
    end
    return (64'd15 << f) | frac;
  endfunction

endpackage
`default_nettype wire

### sv/pgo_chan.sv
// Pipelined power, gain and offset datapath for one 16-bit channel.
`default_nettype none
module pgo_chan import pgo_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [PIX_W-1:0]           x,
  input  logic                       sel,
  input  logic signed [OFFSET_W-1:0] offset,
  input  logic [GAIN_W-1:0]          gain,
  input  logic [EXP_W-1:0]           exponent,
  output logic [PIX_W-1:0]           y
);

  localparam int F  = FRAC_BITS;
  localparam int NS = 2 * F + 9;
  localparam int LW = F + 4;
  localparam int TW = EXP_W + LW - REG_FRAC;
  localparam int KW = $clog2(F + 2);
  localparam int GW = GAIN_W + 1;
  localparam int SW = GW + 2;
  localparam logic [LW-1:0] LOG_FULL = LW'(log2_full(F));
  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};
  localparam logic [TW-F-1:0] K_MAX = (TW-F)'(F + 1);

  logic [PIX_W-1:0] x_p  [0:NS-2];
  logic             xz_p [0:F+2];

  // log2 stages
  logic [3:0]   ln [0:F];
  logic [F:0]   lu [0:F-1];
  logic [F-1:0] lf [0:F];

  logic [3:0]         n0;
  logic [PIX_W+F-1:0] xs0;

  always_comb begin
    n0 = '0;
    for (int i = 0; i < PIX_W; i++) begin
      if (x[i]) n0 = 4'(i);
    end
    xs0 = {x, {F{1'b0}}} >> n0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_p[0]  <= x;
      xz_p[0] <= (x == '0);
      ln[0]   <= n0;
      lu[0]   <= xs0[F:0];
      lf[0]   <= '0;
    end
  end

  for (genvar j = 1; j <= F; j++) begin : g_log
    logic [2*F+1:0] sq;
    logic [F+1:0]   sh;
    logic           b;
    assign sq = lu[j-1] * lu[j-1];
    assign sh = sq[2*F+1:F];
    assign b  = sh[F+1];

    always_ff @(posedge clk) begin
      if (en) begin
        x_p[j]  <= x_p[j-1];
        xz_p[j] <= xz_p[j-1];
        ln[j]   <= ln[j-1];
        lf[j]   <= {lf[j-1][F-2:0], b};
      end
    end

    if (j < F) begin : g_u
      always_ff @(posedge clk) begin
        if (en) begin
          lu[j] <= b ? sh[F+1:1] : sh[F:0];
        end
      end
    end
  end

  // distance from full scale, then scale by exponent
  logic [LW-1:0]        lin;
  logic [LW-1:0]        m;
  logic [EXP_W+LW-1:0]  tprod;
  logic [TW-1:0]        t;
  logic [TW-F-1:0]      k_full;

  assign lin    = {ln[F], lf[F]};
  assign tprod  = exponent * m;
  assign k_full = t[TW-1:F];

  always_ff @(posedge clk) begin
    if (en) begin
      m         <= (LOG_FULL > lin) ? (LOG_FULL - lin) : '0;
      x_p[F+1]  <= x_p[F];
      xz_p[F+1] <= xz_p[F];
      t         <= tprod[EXP_W+LW-1:REG_FRAC];
      x_p[F+2]  <= x_p[F+1];
      xz_p[F+2] <= xz_p[F+1];
    end
  end

  // exp2 stages
  logic [F:0]    acc   [0:F];
  logic [F-1:0]  ge    [0:F-1];
  logic [KW-1:0] ke    [0:F];
  logic          onef  [0:F];
  logic          zerof [0:F];

  always_ff @(posedge clk) begin
    if (en) begin
      acc[0]   <= ONE;
      ge[0]    <= t[F-1:0];
      ke[0]    <= k_full[KW-1:0];
      onef[0]  <= (exponent == '0);
      zerof[0] <= (exponent != '0) && (xz_p[F+2] || (k_full > K_MAX));
      x_p[F+3] <= x_p[F+2];
    end
  end

  for (genvar i = 1; i <= F; i++) begin : g_exp
    localparam logic [F-1:0] RC = F'(exp_root(F, i));
    logic [2*F:0] pr;
    assign pr = acc[i-1] * RC;

    always_ff @(posedge clk) begin
      if (en) begin
        acc[i]     <= ge[i-1][F-i] ? pr[2*F:F] : acc[i-1];
        ke[i]      <= ke[i-1];
        onef[i]    <= onef[i-1];
        zerof[i]   <= zerof[i-1];
        x_p[F+3+i] <= x_p[F+2+i];
      end
    end

    if (i < F) begin : g_g
      always_ff @(posedge clk) begin
        if (en) begin
          ge[i] <= ge[i-1];
        end
      end
    end
  end

  // power, gain, offset, scale, saturate; or pass the sample through when not selected
  logic [F:0]            p;
  logic [GAIN_W+F:0]     gp;
  logic [GW-1:0]         gm;
  logic signed [SW-1:0]  s;
  logic [SW-2+PIX_W-1:0] sprod;
  logic                  pos;
  logic [SW-2-1:0]       r;

  assign gp    = gain * p;
  assign sprod = s[SW-2:0] * FULL_SCALE;

  always_ff @(posedge clk) begin
    if (en) begin
      p            <= onef[F] ? ONE : (zerof[F] ? '0 : (acc[F] >> ke[F]));
      x_p[2*F+4]   <= x_p[2*F+3];
      gm           <= gp[GAIN_W+F:F];
      x_p[2*F+5]   <= x_p[2*F+4];
      s            <= $signed({2'b00, gm}) + $signed({{(SW-OFFSET_W){offset[OFFSET_W-1]}}, offset});
      x_p[2*F+6]   <= x_p[2*F+5];
      pos          <= (s > 0);
      r            <= sprod[SW-2+PIX_W-1:PIX_W];
      x_p[2*F+7]   <= x_p[2*F+6];
      if (!sel) begin
        y <= x_p[2*F+7];
      end else if (!pos) begin
        y <= '0;
      end else if (|r[SW-2-1:PIX_W]) begin
        y <= FULL_SCALE;
      end else begin
        y <= r[PIX_W-1:0];
      end
    end
  end

endmodule
`default_nettype wire

### sv/pixel_gamma_gain_offset.sv
// Top level of the RGBA pixel power, gain and offset adjuster.
// Usage:
//   Input channel in_valid/in_stall carries one pixel (red_in .. alpha_in) per item;
//   output channel out_valid/out_stall returns the adjusted pixel.
//   Channels whose channel_mask bit is set get gain * (x/65535)^exponent + offset,
//   scaled back to 0..65535 with truncation and saturation; others pass unchanged.
//   The pipeline has one squaring stage per log2 fraction bit and one multiply
//   stage per exp2 fraction bit, plus nine more. Throughput is one pixel per
//   cycle while out_stall does not hold the pipeline.
//   When out_stall is high with a result waiting, the whole pipeline holds and
//   in_stall rises in the same cycle; nothing is lost or repeated.
//   Reset clears all item valid bits and loads the registers: channel_mask 7,
//   offset 0, gain 1.0, exponent 1.0. Write registers through cfg_we/cfg_index/
//   cfg_data only while no item is in flight.
`default_nettype none
module pixel_gamma_gain_offset import pgo_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PIX_W-1:0]     red_in,
  input  logic [PIX_W-1:0]     green_in,
  input  logic [PIX_W-1:0]     blue_in,
  input  logic [PIX_W-1:0]     alpha_in,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [PIX_W-1:0]     red_out,
  output logic [PIX_W-1:0]     green_out,
  output logic [PIX_W-1:0]     blue_out,
  output logic [PIX_W-1:0]     alpha_out,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int NS = 2 * FRAC_BITS + 9;

  logic [MASK_W-1:0]          channel_mask;
  logic signed [OFFSET_W-1:0] offset;
  logic [GAIN_W-1:0]          gain;
  logic [EXP_W-1:0]           exponent;
  logic [NS-1:0]              valid_p;
  logic                       en;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_mask <= MASK_RST;
      offset       <= OFFSET_RST;
      gain         <= GAIN_RST;
      exponent     <= EXP_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_MASK:     channel_mask <= cfg_data[MASK_W-1:0];
        REG_OFFSET:   offset       <= cfg_data[OFFSET_W-1:0];
        REG_GAIN:     gain         <= cfg_data[GAIN_W-1:0];
        REG_EXPONENT: exponent     <= cfg_data[EXP_W-1:0];
        default: ;
      endcase
    end
  end

  assign en        = !(valid_p[NS-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = valid_p[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_p <= '0;
    end else if (en) begin
      valid_p <= {valid_p[NS-2:0], in_valid};
    end
  end

  logic [PIX_W-1:0] x_in  [0:NCHAN-1];
  logic [PIX_W-1:0] y_out [0:NCHAN-1];

  assign x_in[0] = red_in;
  assign x_in[1] = green_in;
  assign x_in[2] = blue_in;
  assign x_in[3] = alpha_in;

  for (genvar c = 0; c < NCHAN; c++) begin : g_chan
    pgo_chan #(
      .FRAC_BITS(FRAC_BITS)
    ) u_chan (
      .clk      (clk),
      .en       (en),
      .x        (x_in[c]),
      .sel      (channel_mask[c]),
      .offset   (offset),
      .gain     (gain),
      .exponent (exponent),
      .y        (y_out[c])
    );
  end

  assign red_out   = y_out[0];
  assign green_out = y_out[1];
  assign blue_out  = y_out[2];
  assign alpha_out = y_out[3];

endmodule
`default_nettype wire

### tb/tb_pixel_gamma_gain_offset.sv
// Testbench for pixel_gamma_gain_offset: directed and random pixels, every register, checked result by result.
`default_nettype none
module tb_pixel_gamma_gain_offset;
  import pgo_pkg::*;

  localparam int FB = 16;
  localparam int LATENCY = 2 * FB + 9;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [PIX_W-1:0] r, g, b, a;
  } pixel_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic [PIX_W-1:0] red_in = '0, green_in = '0, blue_in = '0, alpha_in = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [PIX_W-1:0] red_out, green_out, blue_out, alpha_out;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_MASK;
  logic [CFG_W-1:0] cfg_data = '0;

  pixel_gamma_gain_offset #(.FRAC_BITS(FB)) dut (.*);

  always #2 clk = ~clk;

  logic [MASK_W-1:0] mask_q;
  longint offset_q;
  longint unsigned gain_q, exp_q;
  longint unsigned roots[1:FB];
  longint unsigned log_full;

  pixel_t expected_pixels[$];
  int errors = 0;
  int pixels_sent = 0;
  int pixels_checked = 0;
  int idle_pct = 22;
  longint cycles = 0;

  function automatic longint unsigned sqrt_floor(longint unsigned a);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > a) b >>= 2;
    while (b != 0) begin
      if (a >= r + b) begin
        a -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned log2_q(longint unsigned v);
    int n, i;
    longint unsigned u, frac;
    n = 0;
    frac = 0;
    while (n < 15 && (v >> (n + 1)) != 0) n++;
    u = (v << FB) >> n;
    for (i = 0; i < FB; i++) begin
      u = (u * u) >> FB;
      frac <<= 1;
      if (u >= (64'd2 << FB)) begin
        u >>= 1;
        frac |= 1;
      end
    end
    return (longint'(n) << FB) | frac;
  endfunction

  function automatic longint unsigned power_q(longint unsigned x);
    longint unsigned lx, m, t, k, g, acc;
    int i;
    if (exp_q == 0) return 64'd1 << FB;
    if (x == 0) return 0;
    lx = log2_q(x);
    m = (log_full > lx) ? log_full - lx : 0;
    t = (exp_q * m) >> REG_FRAC;
    k = t >> FB;
    g = t & ((64'd1 << FB) - 1);
    if (k > FB + 1) return 0;
    acc = 64'd1 << FB;
    for (i = 1; i <= FB; i++)
      if ((g >> (FB - i)) & 1) acc = (acc * roots[i]) >> FB;
    return acc >> k;
  endfunction

  function automatic logic [PIX_W-1:0] adjust_sample(logic [PIX_W-1:0] x);
    longint s;
    longint unsigned res;
    s = longint'((gain_q * power_q(x)) >> FB) + offset_q;
    if (s <= 0) return '0;
    res = (longint'(s) * 65535) >> REG_FRAC;
    return res > 65535 ? 16'hFFFF : res[15:0];
  endfunction

  function automatic pixel_t predict_pixel(pixel_t p);
    pixel_t o;
    o.r = mask_q[0] ? adjust_sample(p.r) : p.r;
    o.g = mask_q[1] ? adjust_sample(p.g) : p.g;
    o.b = mask_q[2] ? adjust_sample(p.b) : p.b;
    o.a = mask_q[3] ? adjust_sample(p.a) : p.a;
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch %s: got %0d expected %0d (pixel %0d)", what, got, want, pixels_checked);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[pixel_gamma_gain_offset] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    pixel_t w;
    if (!rst && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected pixel", 0, 0);
      end else begin
        w = expected_pixels.pop_front();
        if (red_out !== w.r) report_mismatch("red", int'(red_out), int'(w.r));
        if (green_out !== w.g) report_mismatch("green", int'(green_out), int'(w.g));
        if (blue_out !== w.b) report_mismatch("blue", int'(blue_out), int'(w.b));
        if (alpha_out !== w.a) report_mismatch("alpha", int'(alpha_out), int'(w.a));
      end
      pixels_checked++;
    end
  end

  always @(negedge clk)
    out_stall <= ($urandom_range(99) < idle_pct);

  task automatic send_pixel(pixel_t p);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    red_in <= p.r;
    green_in <= p.g;
    blue_in <= p.b;
    alpha_in <= p.a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_pixels.push_back(predict_pixel(p));
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 0;
    while (expected_pixels.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
    drain();
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    case (idx)
      REG_MASK: mask_q = val[MASK_W-1:0];
      REG_OFFSET: offset_q = longint'(signed'(val[OFFSET_W-1:0]));
      REG_GAIN: gain_q = val[GAIN_W-1:0];
      REG_EXPONENT: exp_q = val[EXP_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [PIX_W-1:0] rand_sample();
    case ($urandom_range(9))
      0: return '0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(15));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic pixel_t rand_pixel();
    return '{rand_sample(), rand_sample(), rand_sample(), rand_sample()};
  endfunction

  task automatic test_reset_defaults;
    send_pixel('{16'h0000, 16'hFFFF, 16'h8000, 16'h1234});
    send_pixel('{16'h0001, 16'h7FFF, 16'hFFFE, 16'hFFFF});
  endtask

  task automatic test_directed_corners;
    write_reg(REG_MASK, 25'hF);
    write_reg(REG_EXPONENT, 25'd0);
    send_pixel('{16'h0000, 16'h0001, 16'hFFFF, 16'h5555});
    write_reg(REG_EXPONENT, 25'd144179);
    send_pixel('{16'h0000, 16'h0001, 16'hFFFF, 16'hAAAA});
    write_reg(REG_EXPONENT, 25'hFFFFFF);
    send_pixel('{16'h0001, 16'hFFFE, 16'hFFFF, 16'h8000});
    write_reg(REG_GAIN, 25'hFFFFFF);
    write_reg(REG_EXPONENT, 25'd32768);
    send_pixel('{16'h0000, 16'h0100, 16'hFFFF, 16'h4000});
    write_reg(REG_GAIN, 25'd0);
    write_reg(REG_OFFSET, 25'h0FFFFFF);
    send_pixel('{16'h0000, 16'h0100, 16'hFFFF, 16'h4000});
    write_reg(REG_OFFSET, 25'h1000000);
    write_reg(REG_GAIN, 25'd65536);
    send_pixel('{16'hFFFF, 16'h1000, 16'h0000, 16'hC000});
    write_reg(REG_OFFSET, 25'h1FF8000);
    write_reg(REG_MASK, 25'h0);
    send_pixel('{16'hFFFF, 16'h0000, 16'h1234, 16'hFEDC});
    write_reg(REG_MASK, 25'hA);
    send_pixel('{16'hFFFF, 16'h8000, 16'h1234, 16'hFEDC});
  endtask

  task automatic test_random_settings;
    int phase, i;
    for (phase = 0; phase < 24; phase++) begin
      write_reg(REG_MASK, 25'($urandom));
      write_reg(REG_OFFSET, ($urandom_range(2) == 0) ? 25'($urandom)
                                                     : 25'($urandom_range(65536) - 32768));
      write_reg(REG_GAIN, ($urandom_range(3) == 0) ? 25'($urandom)
                                                   : 25'($urandom_range(131072)));
      write_reg(REG_EXPONENT, ($urandom_range(3) == 0) ? 25'($urandom)
                                                       : 25'($urandom_range(262144)));
      idle_pct = (phase == 5) ? 0 : 22;
      for (i = 0; i < 50; i++) send_pixel(rand_pixel());
    end
    idle_pct = 22;
  endtask

  initial begin
    mask_q = MASK_RST;
    offset_q = 0;
    gain_q = GAIN_RST;
    exp_q = EXP_RST;
    roots[1] = sqrt_floor(64'd1 << (2 * FB - 1));
    for (int i = 2; i <= FB; i++) roots[i] = sqrt_floor(roots[i-1] << FB);
    log_full = log2_q(65535);
    repeat (4) @(negedge clk);
    rst <= 0;
    test_reset_defaults();
    test_directed_corners();
    test_random_settings();
    drain();
    $display("sent %0d pixels, checked %0d, across reset, corner and random register settings",
             pixels_sent, pixels_checked);
    if (errors == 0 && expected_pixels.size() == 0)
      $display("[pixel_gamma_gain_offset] OK");
    else
      $display("[pixel_gamma_gain_offset] ERROR");
    $finish;
  end
endmodule
`default_nettype wire

### pixel_gamma_gain_offset.f
sv/pgo_pkg.sv
sv/pgo_chan.sv
sv/pixel_gamma_gain_offset.sv
tb/tb_pixel_gamma_gain_offset.sv
